// ----- sv/sce_pkg.sv -----
package sce_pkg;

	// Input item: one logit and its label
	typedef struct packed {
		logic signed [15:0] logit;
		logic               label;
	} in_t;

	// Result item: gradient, per-sample and per-batch losses
	typedef struct packed {
		logic signed [16:0] gradient;
		logic [35:0]        sample_loss;
		logic               sample_done;
		logic [35:0]        mean_loss;
		logic               batch_done;
	} out_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [6:0]  nbits;
		logic [63:0] dividend;
		logic [35:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXP_START,
		ST_EXP_MUL,
		ST_EXP_DIV,
		ST_EXP_WAIT,
		ST_EXP_END,
		ST_INIT_SQ,
		ST_INIT_SQW,
		ST_WHOLE_CHK,
		ST_WHOLE_MUL,
		ST_P_DIV,
		ST_P_WAIT,
		ST_Q_PREP,
		ST_LN_START,
		ST_LN_UW,
		ST_LN_USQ,
		ST_LN_U2,
		ST_LN_MUL,
		ST_LN_DIV,
		ST_LN_WAIT,
		ST_LN_END,
		ST_LOSS_MUL,
		ST_LOSS,
		ST_GRAD_DIV,
		ST_GRAD_WAIT,
		ST_MEAN_DIV,
		ST_MEAN_WAIT,
		ST_OUT
	} state_t;

	// Configuration register indexes
	localparam logic [7:0] REG_EPS = 8'd0;
	localparam logic [7:0] REG_SC  = 8'd1;

	// Quotient lengths for the divider
	localparam logic [6:0] DIV_N_SHORT = 7'd34;
	localparam logic [6:0] DIV_N_MEAN  = 7'd52;
	localparam logic [6:0] DIV_N_LONG  = 7'd64;

	// Series limits
	localparam logic [4:0] EXP_FIRST_K = 5'd2;
	localparam logic [4:0] EXP_LAST_K  = 5'd20;
	localparam logic [4:0] LN_FIRST_K  = 5'd3;
	localparam logic [4:0] LN_LAST_K   = 5'd31;

	// Fixed-point constants
	localparam logic [34:0] ONE_Q32  = 35'h1_0000_0000;
	localparam logic [31:0] HALF_Q32 = 32'h8000_0000;
	localparam logic [63:0] ONE_Q48  = 64'h0001_0000_0000_0000;

endpackage

// ----- sv/sigmoid_cross_entropy_loss_top.sv -----
// Work per item: about 37 passes through the shared radix-2 divider (one quotient bit a cycle),
// plus one multiplier pass per whole unit of |logit|.
// Throughput: one item at a time; in_ready stays low until the result item is taken.
// Reset: arst_n clears counters and sums and sets both registers to 1. After reset a
// pass forms the exp(-1) and ln 2 constants before in_ready rises.
module sigmoid_cross_entropy_loss_top #(
	parameter int LOGIT_FRAC_BITS = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sce_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output sce_pkg::out_t   out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	localparam int F       = LOGIT_FRAC_BITS;
	localparam int WHOLE_W = 16 - F;

	sce_pkg::state_t state_q, state_d;

	logic                init_q;
	logic [15:0]         eps_q, sc_q;
	logic [15:0]         elem_idx_q, samp_idx_q;
	logic [35:0]         sample_sum_q;
	logic [51:0]         batch_sum_q;

	logic                lab_q, lneg_q;
	logic [WHOLE_W-1:0]  whole_q;
	logic [31:0]         y_q;
	logic [32:0]         t_q;
	logic [34:0]         epos_q, eneg_q;
	logic [4:0]          k_q;
	logic [32:0]         e_q;
	logic [31:0]         e1_q;
	logic [32:0]         ln2_q, lz_q;
	logic [15:0]         p_q;
	logic [4:0]          n_q;
	logic [32:0]         z_q;
	logic [31:0]         u_q, u2_q;
	logic [33:0]         lsum_q;
	logic [21:0]         loss_q;
	sce_pkg::out_t       out_q;

	logic [32:0]         mul_a, mul_b;
	logic [65:0]         prod;
	sce_pkg::div_req_t   dreq;
	sce_pkg::div_rsp_t   drsp;

	logic [15:0]         eps_eff, sc_eff;
	logic                sample_end, batch_end;
	logic [15:0]         mag_c;
	logic [33:0]         d_c;
	logic [16:0]         q_c;
	logic [4:0]          n_c;
	logic [16:0]         gmag_c;
	logic [37:0]         lpos_c;
	logic [35:0]         ssum_new;
	logic [51:0]         bsum_new;
	logic [16:0]         gq_c;

	sce_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	sce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Effective register values and end-of-sample / end-of-batch tests
	always_comb begin
		eps_eff    = (eps_q == 16'd0) ? 16'd1 : eps_q;
		sc_eff     = (sc_q == 16'd0) ? 16'd1 : sc_q;
		sample_end = ({1'b0, elem_idx_q} + 17'd1) >= {1'b0, eps_eff};
		batch_end  = ({1'b0, samp_idx_q} + 17'd1) >= {1'b0, sc_eff};
	end

	// Per-item helper values
	always_comb begin
		mag_c    = in_data.logit[15] ? 16'(16'd0 - in_data.logit) : in_data.logit;
		d_c      = sce_pkg::ONE_Q32[33:0] + {1'b0, e_q};
		q_c      = lab_q ? {1'b0, p_q} : (17'h10000 - {1'b0, p_q});
		if (q_c == 17'd0)
			q_c = 17'd1;
		n_c = '0;
		for (int i = 0; i < 17; i++) begin
			if (q_c[i])
				n_c = 5'(i);
		end
		gmag_c   = lab_q ? (17'h10000 - {1'b0, p_q}) : {1'b0, p_q};
		lpos_c   = prod[37:0] - {5'd0, lz_q} + 38'h8000;
		ssum_new = sample_sum_q + 36'(loss_q);
		bsum_new = batch_sum_q + {16'd0, ssum_new};
		gq_c     = drsp.quot[16:0];
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sce_pkg::ST_EXP_MUL: begin
				mul_a = t_q;
				mul_b = {1'b0, y_q};
			end
			sce_pkg::ST_INIT_SQ: begin
				mul_a = e_q;
				mul_b = e_q;
			end
			sce_pkg::ST_WHOLE_CHK: begin
				mul_a = e_q;
				mul_b = {1'b0, e1_q};
			end
			sce_pkg::ST_LN_USQ: begin
				mul_a = {1'b0, u_q};
				mul_b = {1'b0, u_q};
			end
			sce_pkg::ST_LN_MUL: begin
				mul_a = t_q;
				mul_b = {1'b0, u2_q};
			end
			sce_pkg::ST_LOSS_MUL: begin
				mul_a = 33'(5'd16 - n_q);
				mul_b = ln2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared divider requests
	always_comb begin
		dreq = '0;
		case (state_q)
			sce_pkg::ST_EXP_DIV: begin
				dreq.start    = 1'b1;
				dreq.nbits    = sce_pkg::DIV_N_SHORT;
				dreq.dividend = 64'(prod[65:32]);
				dreq.divisor  = 36'(k_q);
			end
			sce_pkg::ST_P_DIV: begin
				dreq.start    = 1'b1;
				dreq.nbits    = sce_pkg::DIV_N_LONG;
				dreq.dividend = lneg_q ? ({15'd0, e_q, 16'd0} + 64'(d_c[33:1]))
				                       : (sce_pkg::ONE_Q48 + 64'(d_c[33:1]));
				dreq.divisor  = 36'(d_c);
			end
			sce_pkg::ST_LN_START: begin
				dreq.start    = 1'b1;
				dreq.nbits    = sce_pkg::DIV_N_LONG;
				dreq.dividend = {32'(z_q - 33'(sce_pkg::HALF_Q32)), 32'd0};
				dreq.divisor  = 36'(z_q) + 36'(sce_pkg::HALF_Q32);
			end
			sce_pkg::ST_LN_DIV: begin
				dreq.start    = 1'b1;
				dreq.nbits    = sce_pkg::DIV_N_SHORT;
				dreq.dividend = 64'(prod[63:32]);
				dreq.divisor  = 36'(k_q);
			end
			sce_pkg::ST_GRAD_DIV: begin
				dreq.start    = 1'b1;
				dreq.nbits    = sce_pkg::DIV_N_SHORT;
				dreq.dividend = 64'(gmag_c);
				dreq.divisor  = 36'(sc_eff);
			end
			sce_pkg::ST_MEAN_DIV: begin
				dreq.start    = 1'b1;
				dreq.nbits    = sce_pkg::DIV_N_MEAN;
				dreq.dividend = 64'(batch_sum_q);
				dreq.divisor  = 36'(sc_eff);
			end
			default: dreq = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sce_pkg::ST_INIT;
		else
			state_q <= state_d;
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sce_pkg::ST_INIT:      state_d = sce_pkg::ST_EXP_START;
			sce_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = sce_pkg::ST_EXP_START;
			end
			sce_pkg::ST_EXP_START: state_d = sce_pkg::ST_EXP_MUL;
			sce_pkg::ST_EXP_MUL:   state_d = sce_pkg::ST_EXP_DIV;
			sce_pkg::ST_EXP_DIV:   state_d = sce_pkg::ST_EXP_WAIT;
			sce_pkg::ST_EXP_WAIT: begin
				if (drsp.done)
					state_d = (k_q == sce_pkg::EXP_LAST_K) ? sce_pkg::ST_EXP_END
					                                        : sce_pkg::ST_EXP_MUL;
			end
			sce_pkg::ST_EXP_END:
				state_d = init_q ? sce_pkg::ST_INIT_SQ : sce_pkg::ST_WHOLE_CHK;
			sce_pkg::ST_INIT_SQ:   state_d = sce_pkg::ST_INIT_SQW;
			sce_pkg::ST_INIT_SQW:  state_d = sce_pkg::ST_LN_START;
			sce_pkg::ST_WHOLE_CHK:
				state_d = (whole_q == '0 || e_q == '0) ? sce_pkg::ST_P_DIV
				                                       : sce_pkg::ST_WHOLE_MUL;
			sce_pkg::ST_WHOLE_MUL: state_d = sce_pkg::ST_WHOLE_CHK;
			sce_pkg::ST_P_DIV:     state_d = sce_pkg::ST_P_WAIT;
			sce_pkg::ST_P_WAIT: begin
				if (drsp.done)
					state_d = sce_pkg::ST_Q_PREP;
			end
			sce_pkg::ST_Q_PREP:    state_d = sce_pkg::ST_LN_START;
			sce_pkg::ST_LN_START:  state_d = sce_pkg::ST_LN_UW;
			sce_pkg::ST_LN_UW: begin
				if (drsp.done)
					state_d = sce_pkg::ST_LN_USQ;
			end
			sce_pkg::ST_LN_USQ:    state_d = sce_pkg::ST_LN_U2;
			sce_pkg::ST_LN_U2:     state_d = sce_pkg::ST_LN_MUL;
			sce_pkg::ST_LN_MUL:    state_d = sce_pkg::ST_LN_DIV;
			sce_pkg::ST_LN_DIV:    state_d = sce_pkg::ST_LN_WAIT;
			sce_pkg::ST_LN_WAIT: begin
				if (drsp.done)
					state_d = (k_q == sce_pkg::LN_LAST_K) ? sce_pkg::ST_LN_END
					                                       : sce_pkg::ST_LN_MUL;
			end
			sce_pkg::ST_LN_END:
				state_d = init_q ? sce_pkg::ST_IDLE : sce_pkg::ST_LOSS_MUL;
			sce_pkg::ST_LOSS_MUL:  state_d = sce_pkg::ST_LOSS;
			sce_pkg::ST_LOSS:      state_d = sce_pkg::ST_GRAD_DIV;
			sce_pkg::ST_GRAD_DIV:  state_d = sce_pkg::ST_GRAD_WAIT;
			sce_pkg::ST_GRAD_WAIT: begin
				if (drsp.done)
					state_d = (sample_end && batch_end) ? sce_pkg::ST_MEAN_DIV
					                                    : sce_pkg::ST_OUT;
			end
			sce_pkg::ST_MEAN_DIV:  state_d = sce_pkg::ST_MEAN_WAIT;
			sce_pkg::ST_MEAN_WAIT: begin
				if (drsp.done)
					state_d = sce_pkg::ST_OUT;
			end
			sce_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = sce_pkg::ST_IDLE;
			end
			default: state_d = sce_pkg::ST_INIT;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
			sc_q  <= 16'd1;
		end else if (cfg_valid) begin
			if (cfg_index == sce_pkg::REG_EPS)
				eps_q <= cfg_data;
			else if (cfg_index == sce_pkg::REG_SC)
				sc_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// Control state: constant-forming pass, counters and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= 1'b1;
			elem_idx_q   <= '0;
			samp_idx_q   <= '0;
			sample_sum_q <= '0;
			batch_sum_q  <= '0;
		end else begin
			case (state_q)
				sce_pkg::ST_LN_END: init_q <= 1'b0;
				sce_pkg::ST_GRAD_WAIT: begin
					if (drsp.done) begin
						if (sample_end) begin
							sample_sum_q <= '0;
							elem_idx_q   <= '0;
							batch_sum_q  <= bsum_new;
							if (!batch_end)
								samp_idx_q <= samp_idx_q + 16'd1;
						end else begin
							sample_sum_q <= ssum_new;
							elem_idx_q   <= elem_idx_q + 16'd1;
						end
					end
				end
				sce_pkg::ST_MEAN_WAIT: begin
					if (drsp.done) begin
						batch_sum_q <= '0;
						samp_idx_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			sce_pkg::ST_INIT: y_q <= sce_pkg::HALF_Q32;
			sce_pkg::ST_IDLE: begin
				if (in_valid) begin
					lab_q   <= in_data.label;
					lneg_q  <= in_data.logit[15];
					whole_q <= mag_c[15:F];
					y_q     <= {mag_c[F-1:0], {(32-F){1'b0}}};
				end
			end
			sce_pkg::ST_EXP_START: begin
				t_q    <= {1'b0, y_q};
				eneg_q <= 35'(y_q);
				epos_q <= sce_pkg::ONE_Q32;
				k_q    <= sce_pkg::EXP_FIRST_K;
			end
			sce_pkg::ST_EXP_WAIT: begin
				if (drsp.done) begin
					t_q <= drsp.quot[32:0];
					if (k_q[0])
						eneg_q <= eneg_q + 35'(drsp.quot[32:0]);
					else
						epos_q <= epos_q + 35'(drsp.quot[32:0]);
					k_q <= k_q + 5'd1;
				end
			end
			sce_pkg::ST_EXP_END:
				e_q <= (epos_q > eneg_q) ? 33'(epos_q - eneg_q) : 33'd0;
			sce_pkg::ST_INIT_SQW: begin
				e1_q <= prod[63:32];
				z_q  <= sce_pkg::ONE_Q32[32:0];
			end
			sce_pkg::ST_WHOLE_MUL: begin
				e_q     <= prod[64:32];
				whole_q <= whole_q - WHOLE_W'(1);
			end
			sce_pkg::ST_P_WAIT: begin
				if (drsp.done)
					p_q <= (drsp.quot > 64'd65535) ? 16'hFFFF : drsp.quot[15:0];
			end
			sce_pkg::ST_Q_PREP: begin
				n_q <= n_c;
				z_q <= 33'(q_c) << (5'd31 - n_c);
			end
			sce_pkg::ST_LN_UW: begin
				if (drsp.done)
					u_q <= drsp.quot[31:0];
			end
			sce_pkg::ST_LN_U2: begin
				u2_q   <= prod[63:32];
				t_q    <= {1'b0, u_q};
				lsum_q <= 34'(u_q);
				k_q    <= sce_pkg::LN_FIRST_K;
			end
			sce_pkg::ST_LN_DIV: t_q <= {1'b0, prod[63:32]};
			sce_pkg::ST_LN_WAIT: begin
				if (drsp.done) begin
					lsum_q <= lsum_q + drsp.quot[33:0];
					k_q    <= k_q + 5'd2;
				end
			end
			sce_pkg::ST_LN_END: begin
				if (init_q)
					ln2_q <= {lsum_q[31:0], 1'b0};
				else
					lz_q <= {lsum_q[31:0], 1'b0};
			end
			sce_pkg::ST_LOSS:
				loss_q <= (prod[37:0] > {5'd0, lz_q}) ? lpos_c[37:16] : 22'd0;
			sce_pkg::ST_GRAD_WAIT: begin
				if (drsp.done) begin
					out_q.gradient    <= lab_q ? signed'(17'd0 - gq_c) : signed'(gq_c);
					out_q.sample_loss <= sample_end ? ssum_new : 36'd0;
					out_q.sample_done <= sample_end;
					out_q.mean_loss   <= '0;
					out_q.batch_done  <= sample_end && batch_end;
				end
			end
			sce_pkg::ST_MEAN_WAIT: begin
				if (drsp.done)
					out_q.mean_loss <= drsp.quot[35:0];
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

// ----- sv/sce_mul.sv -----
module sce_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] prod
);

	logic [65:0] prod_q;

	// Register the product of the shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= 66'(a) * 66'(b);
	end

	assign prod = prod_q;

endmodule

// ----- sv/sce_div.sv -----
module sce_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sce_pkg::div_req_t   req,
	output sce_pkg::div_rsp_t   rsp
);

	logic [63:0] dvd_q;
	logic [35:0] dsr_q;
	logic [35:0] rem_q;
	logic [63:0] quot_q;
	logic [6:0]  cnt_q;
	logic        done_q;

	logic [36:0] remx;
	logic [36:0] diff;
	logic        ge;
	logic [6:0]  sh;

	// One restoring step: bring down the next dividend bit and try a subtract
	always_comb begin
		remx = {rem_q, dvd_q[63]};
		ge   = remx >= {1'b0, dsr_q};
		diff = remx - {1'b0, dsr_q};
		sh   = 7'd64 - req.nbits;
	end

	// Control: count the quotient bits, pulse done on the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.nbits;
			done_q <= 1'b0;
		end else if (cnt_q != 7'd0) begin
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: align the dividend on start, then shift one bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend << sh;
			dsr_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (cnt_q != 7'd0) begin
			dvd_q  <= {dvd_q[62:0], 1'b0};
			rem_q  <= ge ? diff[35:0] : remx[35:0];
			quot_q <= {quot_q[62:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
